FILE: rtl/i3p_pkg.sv
// Shared types and constants for the ID3v2 text frame parser.
// Used by i3p_classify, i3p_core and id3v2_text_frame_parser; no dependencies.
package i3p_pkg;

  // Fields longer than this many characters are cut
  localparam logic [7:0] TEXT_LIMIT = 8'd255;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ARTIST = 2'd1,
    KIND_TITLE  = 2'd2,
    KIND_ALBUM  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
  } in_item_t;

  typedef struct packed {
    logic       text_valid;
    logic [1:0] field_kind;
    logic [7:0] text_byte;
    logic       field_end;
    logic       parse_done;
    logic [2:0] parse_status;
  } out_item_t;

endpackage

FILE: rtl/i3p_classify.sv
// Frame label decoder: maps a 3- or 4-byte frame label to a text field kind.
// Depends on i3p_pkg.
module i3p_classify (
  input  logic [31:0]         label,
  input  logic                wide,
  output i3p_pkg::kind_t      kind
);

  localparam logic [23:0] LBL_TP1  = "TP1";
  localparam logic [23:0] LBL_TT2  = "TT2";
  localparam logic [23:0] LBL_TAL  = "TAL";
  localparam logic [31:0] LBL_TOLY = "TOLY";
  localparam logic [31:0] LBL_TOPE = "TOPE";
  localparam logic [31:0] LBL_TPE1 = "TPE1";
  localparam logic [31:0] LBL_TPE2 = "TPE2";
  localparam logic [31:0] LBL_TIT2 = "TIT2";

  logic [23:0] l3;
  logic        artist4;

  // v3/v4 labels are four bytes; the short labels match on their first three
  assign l3      = wide ? label[31:8] : label[23:0];
  assign artist4 = wide && (label == LBL_TOLY || label == LBL_TOPE ||
                            label == LBL_TPE1 || label == LBL_TPE2);

  always_comb begin
    if (l3 == LBL_TP1 || artist4) begin
      kind = i3p_pkg::KIND_ARTIST;
    end else if (l3 == LBL_TT2 || (wide && label == LBL_TIT2)) begin
      kind = i3p_pkg::KIND_TITLE;
    end else if (l3 == LBL_TAL) begin
      kind = i3p_pkg::KIND_ALBUM;
    end else begin
      kind = i3p_pkg::KIND_NONE;
    end
  end

endmodule

FILE: rtl/i3p_core.sv
// Tag walker: parse state registers and the per-byte next-state/result logic.
// Depends on i3p_pkg and i3p_classify.
module i3p_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  i3p_pkg::in_item_t   item,
  output logic                has_result,
  output i3p_pkg::out_item_t  result
);

  localparam logic [2:0]  ST_OK        = 3'd0;
  localparam logic [2:0]  ST_NO_MAGIC  = 3'd1;
  localparam logic [2:0]  ST_BAD_VER   = 3'd2;
  localparam logic [2:0]  ST_EMPTY_TAG = 3'd3;
  localparam logic [2:0]  ST_EARLY_END = 3'd4;
  localparam logic [28:0] POS_MAX      = '1;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_FRAME,
    PH_ENC,
    PH_BODY,
    PH_IDLE
  } phase_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = "I";
      2'd1:    m = "D";
      default: m = "3";
    endcase
    return m;
  endfunction

  phase_t          phase_r, phase_nxt;
  logic [28:0]     pos_r, pos_nxt;
  logic [2:0]      major_r, major_nxt;
  logic [28:0]     tag_end_r, tag_end_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic [31:0]     label_r, label_nxt;
  logic [31:0]     remain_r, remain_nxt;
  i3p_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0]      count_r, count_nxt;
  logic            open_r, open_nxt;

  logic [7:0]      b;
  logic            wide;
  logic [3:0]      label_len, size_end, hdr_len;
  logic [3:0]      idx_inc;
  logic [27:0]     tend_acc;
  logic [31:0]     label_base, remain_base, remain_dec;
  logic [29:0]     pos_inc;
  logic [7:0]      count_inc;
  i3p_pkg::kind_t  class_kind;

  logic            tv, fe, done, boundary;
  logic [1:0]      fk;
  logic [7:0]      tb;
  logic [2:0]      st;

  assign b           = item.data_byte;
  assign wide        = (major_r >= 3'd3);
  assign label_len   = wide ? 4'd4 : 4'd3;
  assign size_end    = wide ? 4'd8 : 4'd6;
  assign hdr_len     = wide ? 4'd10 : 4'd6;
  assign idx_inc     = idx_r + 4'd1;
  assign tend_acc    = {tag_end_r[20:0], b[6:0]};
  assign label_base  = (idx_r == 4'd0) ? 32'd0 : label_r;
  assign remain_base = (idx_r == 4'd0) ? 32'd0 : remain_r;
  assign remain_dec  = remain_r - 32'd1;
  assign pos_inc     = {1'b0, pos_r} + 30'd1;
  assign count_inc   = count_r + 8'd1;

  i3p_classify u_classify (
    .label (label_nxt),
    .wide  (wide),
    .kind  (class_kind)
  );

  always_comb begin
    phase_nxt   = phase_r;
    major_nxt   = major_r;
    tag_end_nxt = tag_end_r;
    idx_nxt     = idx_r;
    label_nxt   = label_r;
    remain_nxt  = remain_r;
    kind_nxt    = kind_r;
    count_nxt   = count_r;
    open_nxt    = open_r;
    tv          = 1'b0;
    fk          = i3p_pkg::KIND_NONE;
    tb          = 8'd0;
    fe          = 1'b0;
    done        = 1'b0;
    st          = ST_OK;
    boundary    = 1'b0;

    unique case (phase_r)
      PH_TAG: begin
        if (idx_r < 4'd3) begin
          if (b != magic_byte(idx_r[1:0])) begin
            done = 1'b1;
            st   = ST_NO_MAGIC;
          end
        end else if (idx_r == 4'd3) begin
          if (b < 8'd2 || b > 8'd4) begin
            done = 1'b1;
            st   = ST_BAD_VER;
          end else begin
            major_nxt = b[2:0];
          end
        end else if (idx_r >= 4'd6) begin
          tag_end_nxt = {1'b0, tend_acc};
          if (idx_r == 4'd9) begin
            if (tend_acc == 28'd0) begin
              done = 1'b1;
              st   = ST_EMPTY_TAG;
            end else begin
              // tag end counts the 10-byte header
              tag_end_nxt = {1'b0, tend_acc} + 29'd10;
            end
          end
        end
        idx_nxt = idx_inc;
        if (idx_r >= 4'd9) begin
          phase_nxt = PH_FRAME;
          idx_nxt   = 4'd0;
        end
      end
      PH_FRAME: begin
        if (idx_r == 4'd0 && b == 8'd0) begin
          done = 1'b1;   // padding
        end else begin
          label_nxt  = label_base;
          remain_nxt = remain_base;
          if (idx_r < label_len) begin
            label_nxt = {label_base[23:0], b};
          end else if (idx_r < size_end) begin
            remain_nxt = (major_r == 3'd4) ? {remain_base[24:0], b[6:0]}
                                           : {remain_base[23:0], b};
          end
          idx_nxt = idx_inc;
          if (idx_inc >= hdr_len) begin
            kind_nxt = class_kind;
            idx_nxt  = 4'd0;
            if (remain_nxt == 32'd0) begin
              boundary = 1'b1;
            end else begin
              phase_nxt = PH_ENC;
            end
          end
        end
      end
      PH_ENC: begin
        remain_nxt = remain_dec;
        if (kind_r != i3p_pkg::KIND_NONE && b == 8'd0) begin
          if (remain_dec == 32'd0) begin
            fe = 1'b1;
            fk = kind_r;
          end else begin
            open_nxt  = 1'b1;
            count_nxt = 8'd0;
          end
        end else begin
          kind_nxt = i3p_pkg::KIND_NONE;
        end
        if (remain_dec == 32'd0) begin
          boundary = 1'b1;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        remain_nxt = remain_dec;
        if (open_r) begin
          fk = kind_r;
          if (b == 8'd0) begin
            fe       = 1'b1;
            open_nxt = 1'b0;
          end else begin
            tv        = 1'b1;
            tb        = b;
            count_nxt = count_inc;
            if (remain_dec == 32'd0 || count_inc >= i3p_pkg::TEXT_LIMIT) begin
              fe       = 1'b1;
              open_nxt = 1'b0;
            end
          end
        end
        if (remain_dec == 32'd0) begin
          boundary = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // end of a frame: stop at the tag end, otherwise expect the next header
    if (boundary) begin
      open_nxt = 1'b0;
      if (pos_inc >= {1'b0, tag_end_r}) begin
        done = 1'b1;
      end else begin
        phase_nxt = PH_FRAME;
        idx_nxt   = 4'd0;
      end
    end

    if (phase_r != PH_IDLE && !done && item.buffer_last) begin
      done = 1'b1;
      st   = ST_EARLY_END;
      if (open_nxt) begin
        fe = 1'b1;
        fk = kind_nxt;
      end
    end

    if (done) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign pos_nxt    = (pos_r != POS_MAX) ? pos_inc[28:0] : pos_r;
  assign has_result = tv | fe | done;

  always_comb begin
    result.text_valid   = tv;
    result.field_kind   = fk;
    result.text_byte    = tb;
    result.field_end    = fe;
    result.parse_done   = done;
    result.parse_status = st;
  end

  // a final buffer byte re-arms the walker
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.buffer_last)) begin
      phase_r   <= PH_TAG;
      pos_r     <= '0;
      major_r   <= '0;
      tag_end_r <= '0;
      idx_r     <= '0;
      label_r   <= '0;
      remain_r  <= '0;
      kind_r    <= i3p_pkg::KIND_NONE;
      count_r   <= '0;
      open_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      major_r   <= major_nxt;
      tag_end_r <= tag_end_nxt;
      idx_r     <= idx_nxt;
      label_r   <= label_nxt;
      remain_r  <= remain_nxt;
      kind_r    <= kind_nxt;
      count_r   <= count_nxt;
      open_r    <= open_nxt;
    end
  end

endmodule

FILE: rtl/id3v2_text_frame_parser.sv
// Top level of the ID3v2 text frame parser: input register, result register
// and valid/stall handshakes around the tag walker. Depends on i3p_pkg, i3p_core.
//
// Usage: the file buffer enters one byte per item on in_data (data_byte,
// buffer_last). Each item updates the walker and yields zero or one result
// item on out_data: a text character tagged with its field kind, a field end,
// or the final parse status when the walk is done.
// Throughput: one byte per cycle, sustained, while the result side takes
// items. An accepted byte goes first into the input register; its result
// goes into the result register when the byte advances, and out_valid
// shows it from there until it is taken.
// Stall: when out_stall holds a waiting result, the input register still
// absorbs one more byte; bytes that give no result keep flowing through,
// and in_stall rises only when the next result has nowhere to go.
// Reset (rst_n low, synchronous) empties both registers and returns the
// walker to the tag header. A byte with buffer_last set re-arms the walker
// the same way, so the next byte is taken as the start of a new buffer.
module id3v2_text_frame_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i3p_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i3p_pkg::out_item_t  out_data
);

  logic                in_valid_r;
  i3p_pkg::in_item_t   in_item_r;
  logic                out_valid_r;
  i3p_pkg::out_item_t  out_item_r;

  logic                has_res;
  i3p_pkg::out_item_t  res;
  logic                out_free;
  logic                advance;
  logic                accept;

  assign out_free = !out_valid_r || !out_stall;
  // a byte that yields no result may pass even while the output is held
  assign advance  = in_valid_r && (out_free || !has_res);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  i3p_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (in_item_r),
    .has_result (has_res),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance && has_res) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
    if (advance && has_res) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
